[hw/rtl/ord_pkg.sv]
// Shared types and constants for the overwrite ring deque.
// Used by ord_ctrl, ord_datapath and overwrite_ring_deque; depends on nothing.
package ord_pkg;

   localparam int SLOTS_DEFAULT     = 16;
   localparam int MSG_BYTES_DEFAULT = 8;

   localparam int MSG_W   = 64;
   localparam int BCNT_W  = 4;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      OP_CLEAR      = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_PUSH_BACK  = 2'd2,
      OP_POP_FRONT  = 2'd3
   } op_type;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      op_type              operation;
      logic [MSG_W-1:0]    message_data;
      logic [BCNT_W-1:0]   byte_count;
   } req_type;

   typedef struct packed {
      logic [MSG_W-1:0]    message_out;
      logic                status;
      logic [COUNT_W-1:0]  entry_count;
      logic                overwrote;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic out_free;
   } sts_type;

endpackage

[hw/rtl/ord_ctrl.sv]
// Sequencer for the ring deque: start-up clearing sweep, accept, result load.
// Depends on ord_pkg; drives the datapath through cmd_type, reads sts_type.
module ord_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ord_pkg::sts_type sts,
   output ord_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.clear_step = 1'b0;
      cmd.accept     = 1'b0;
      cmd.load_rsp   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait for the result register to free up
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/ord_datapath.sv]
// Ring store, front/back pointers, entry count and result register.
// Depends on ord_pkg; steered by ord_ctrl through cmd_type.
module ord_datapath #(
   parameter int SLOTS     = ord_pkg::SLOTS_DEFAULT,
   parameter int MSG_BYTES = ord_pkg::MSG_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  ord_pkg::cmd_type cmd,
   output ord_pkg::sts_type sts,
   input  ord_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ord_pkg::rsp_type rsp_data
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int SLOT_W = MSG_BYTES * 8;

   logic [SLOT_W-1:0]    mem [SLOTS];

   logic [IDX_W-1:0]     front_ff, front_in;
   logic [IDX_W-1:0]     back_ff, back_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic                 out_valid_ff, out_valid_in;

   logic [SLOT_W-1:0]    rdata_ff;
   logic [MSG_BYTES-1:0] pend_be_ff;
   logic                 pend_pop_ff;
   logic                 pend_sts_ff;
   logic                 pend_over_ff;
   ord_pkg::rsp_type     out_data_ff;

   logic [MSG_BYTES-1:0] byte_en;
   logic [MSG_BYTES-1:0] wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [SLOT_W-1:0]    wr_data;
   logic                 rd_en;
   logic                 full;
   logic                 empty;
   logic                 over;
   logic                 empty_pop;
   logic [IDX_W-1:0]     front_dec;
   logic [IDX_W-1:0]     front_inc;
   logic [IDX_W-1:0]     back_inc;
   logic [SLOT_W-1:0]    rd_masked;

   assign full  = (cnt_ff == CNT_W'(SLOTS));
   assign empty = (cnt_ff == '0);

   assign front_dec = (front_ff == '0) ? IDX_W'(SLOTS - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_W'(SLOTS - 1)) ? '0 : front_ff + 1'b1;
   assign back_inc  = (back_ff == IDX_W'(SLOTS - 1)) ? '0 : back_ff + 1'b1;

   // bytes past the saturated byte count are left alone
   always_comb begin
      for (int b = 0; b < MSG_BYTES; b++) begin
         byte_en[b] = (req_data.byte_count > ord_pkg::BCNT_W'(b));
      end
   end

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      cnt_in    = cnt_ff;
      wr_en     = '0;
      wr_addr   = back_ff;
      wr_data   = req_data.message_data[SLOT_W-1:0];
      rd_en     = 1'b0;
      over      = 1'b0;
      empty_pop = 1'b0;
      if (cmd.clear_step) begin
         wr_en   = '1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (cmd.accept) begin
         case (req_data.operation)
            ord_pkg::OP_CLEAR: begin
               front_in = '0;
               back_in  = '0;
               cnt_in   = '0;
            end
            ord_pkg::OP_PUSH_FRONT: begin
               wr_en    = byte_en;
               wr_addr  = front_dec;
               front_in = front_dec;
               if (full) begin
                  back_in = front_dec;
                  over    = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            ord_pkg::OP_PUSH_BACK: begin
               wr_en   = byte_en;
               wr_addr = back_ff;
               back_in = back_inc;
               if (full) begin
                  front_in = back_inc;
                  over     = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            ord_pkg::OP_POP_FRONT: begin
               if (empty) begin
                  empty_pop = 1'b1;
               end else begin
                  rd_en    = 1'b1;
                  front_in = front_inc;
                  cnt_in   = cnt_ff - 1'b1;
               end
            end
            default: begin
               front_in = front_ff;
            end
         endcase
      end
   end

   assign clr_in = cmd.clear_step ? clr_ff + 1'b1 : clr_ff;

   always_comb begin
      for (int b = 0; b < MSG_BYTES; b++) begin
         rd_masked[b*8 +: 8] = (pend_pop_ff && pend_be_ff[b]) ? rdata_ff[b*8 +: 8] : 8'd0;
      end
   end

   assign out_valid_in = cmd.load_rsp ? 1'b1 : (out_valid_ff && rsp_stall);

   assign sts.clear_done = (clr_ff == IDX_W'(SLOTS - 1));
   assign sts.out_free   = !out_valid_ff || !rsp_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // store: byte-enable write port, registered read at the front pointer
   always_ff @(posedge clock) begin
      for (int b = 0; b < MSG_BYTES; b++) begin
         if (wr_en[b]) begin
            mem[wr_addr][b*8 +: 8] <= wr_data[b*8 +: 8];
         end
      end
      if (rd_en) begin
         rdata_ff <= mem[front_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_be_ff   <= byte_en;
         pend_pop_ff  <= rd_en;
         pend_sts_ff  <= empty_pop ? ord_pkg::STATUS_EMPTY : ord_pkg::STATUS_OK;
         pend_over_ff <= over;
      end
      if (cmd.load_rsp) begin
         out_data_ff.message_out <= ord_pkg::MSG_W'(rd_masked);
         out_data_ff.status      <= pend_sts_ff;
         out_data_ff.entry_count <= ord_pkg::COUNT_W'(cnt_ff);
         out_data_ff.overwrote   <= pend_over_ff;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SLOTS))
      else $error("entry count beyond slot count");

   a_empty_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ord_pkg::STATUS_EMPTY |-> rsp_data.message_out == '0)
      else $error("empty pop returned data");

   a_over_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overwrote |-> rsp_data.entry_count == ord_pkg::COUNT_W'(SLOTS))
      else $error("overwrite reported while not full");

   a_clear_op: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && req_data.operation == ord_pkg::OP_CLEAR |=> cnt_ff == '0 && front_ff == '0)
      else $error("clear did not reset pointers");

endmodule

[hw/rtl/overwrite_ring_deque.sv]
// Double-ended ring of SLOTS message slots with overwrite on full.
// Depends on ord_pkg, ord_ctrl and ord_datapath.
//
// After reset the block zeroes its store one slot per cycle and holds
// req_stall high until every slot has been cleared. After that each
// word is accepted in ST_IDLE, where pointers, count and any write are
// settled and the slot store is read into a register, and then in ST_EXEC
// the result goes into the output register once that register is free. The
// store has one write port and one read port, and only one word is in
// flight at a time. A pending result in the output register does not block
// acceptance of the next word. Exactly one result word is produced per
// request word.
module overwrite_ring_deque #(
   parameter int SLOTS     = ord_pkg::SLOTS_DEFAULT,
   parameter int MSG_BYTES = ord_pkg::MSG_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ord_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ord_pkg::rsp_type rsp_data
);

   ord_pkg::cmd_type cmd;
   ord_pkg::sts_type sts;

   ord_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ord_datapath #(
      .SLOTS     (SLOTS),
      .MSG_BYTES (MSG_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
